// ===== sv/jcb_pkg.sv =====
// Shared types and constants for the comment blanker.
package jcb_pkg;

	localparam logic [1:0] MODE_CODE  = 2'd0;
	localparam logic [1:0] MODE_STR   = 2'd1;
	localparam logic [1:0] MODE_BLOCK = 2'd2;
	localparam logic [1:0] MODE_LINE  = 2'd3;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = 8'h20;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       is_final;
	} in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_final;
	} out_t;

	// One lexer step's output: one or two bytes.
	typedef struct packed {
		logic       two;
		logic [7:0] b0;
		logic [7:0] b1;
		logic       fin;
	} q_entry_t;

	typedef struct packed {
		logic     push;
		q_entry_t ent;
	} q_wr_t;

	typedef struct packed {
		logic     empty;
		q_entry_t head;
	} q_rd_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       held;
	} lex_stat_t;

endpackage

// ===== sv/jcb_stream_if.sv =====
// Valid/ready stream channel with a typed payload.
interface jcb_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/jcb_front.sv =====
// Front end: accepts text bytes, runs the lexer and pushes emitted bytes to the queue.
module jcb_front import jcb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	jcb_stream_if.sink         rx,
	input  logic               full,
	output q_wr_t              wr,
	output lex_stat_t          stat
);

	typedef struct packed {
		logic       put;
		logic [7:0] ch;
		logic       hold;
		logic [1:0] mode;
	} take_t;

	logic [1:0] mode_q;
	logic       held_q;
	logic       pbs_q;

	logic [1:0] mode_d;
	logic       held_d;
	logic       pbs_d;
	logic [1:0] n;
	logic [7:0] e0, e1;
	logic       accept;
	take_t      tk;

	// Handling of one byte with nothing held.
	function automatic take_t take(input logic [1:0] md, input logic [7:0] b,
		input logic fin, input logic pb);
		take_t r;
		r.put  = 1'b1;
		r.ch   = b;
		r.hold = 1'b0;
		r.mode = md;
		unique case (md)
			MODE_CODE: begin
				if (b == CH_QUOTE && !pb) begin
					r.mode = MODE_STR;
				end else if (b == CH_SLASH && !fin) begin
					r.put  = 1'b0;
					r.hold = 1'b1;
				end
			end
			MODE_STR: begin
				if (b == CH_QUOTE && !pb)
					r.mode = MODE_CODE;
			end
			MODE_BLOCK: begin
				if (b == CH_STAR && !fin) begin
					r.put  = 1'b0;
					r.hold = 1'b1;
				end else if (b != CH_LF && b != CH_CR) begin
					r.ch = CH_SP;
				end
			end
			default: begin
				if (b == CH_LF || b == CH_CR)
					r.mode = MODE_CODE;
				else
					r.ch = CH_SP;
			end
		endcase
		return r;
	endfunction

	assign rx.ready = !full;
	assign accept   = rx.valid && rx.ready;

	always_comb begin
		mode_d = mode_q;
		held_d = 1'b0;
		pbs_d  = pbs_q;
		n      = 2'd0;
		e0     = CH_SP;
		e1     = CH_SP;
		tk     = '0;
		if (held_q && mode_q == MODE_CODE &&
			(rx.payload.in_byte == CH_STAR || rx.payload.in_byte == CH_SLASH)) begin
			mode_d = (rx.payload.in_byte == CH_STAR) ? MODE_BLOCK : MODE_LINE;
			n      = 2'd2;
			pbs_d  = 1'b0;
		end else if (held_q && mode_q == MODE_BLOCK && rx.payload.in_byte == CH_SLASH) begin
			mode_d = MODE_CODE;
			n      = 2'd2;
			pbs_d  = 1'b0;
		end else begin
			// unpaired held byte goes out first; held in string/line mode is dropped
			if (held_q && (mode_q == MODE_CODE || mode_q == MODE_BLOCK)) begin
				e0    = (mode_q == MODE_CODE) ? CH_SLASH : CH_SP;
				n     = 2'd1;
				pbs_d = 1'b0;
			end
			tk     = take(mode_q, rx.payload.in_byte, rx.payload.is_final, pbs_d);
			mode_d = tk.mode;
			held_d = tk.hold;
			if (tk.put) begin
				if (n == 2'd0)
					e0 = tk.ch;
				else
					e1 = tk.ch;
				n     = n + 2'd1;
				pbs_d = (tk.ch == CH_BSL);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_CODE;
			held_q <= 1'b0;
			pbs_q  <= 1'b0;
		end else if (accept) begin
			if (rx.payload.is_final) begin
				mode_q <= MODE_CODE;
				held_q <= 1'b0;
				pbs_q  <= 1'b0;
			end else begin
				mode_q <= mode_d;
				held_q <= held_d;
				pbs_q  <= pbs_d;
			end
		end
	end

	assign wr.push    = accept && (n != 2'd0);
	assign wr.ent.two = (n == 2'd2);
	assign wr.ent.b0  = e0;
	assign wr.ent.b1  = e1;
	assign wr.ent.fin = rx.payload.is_final;

	assign stat.mode = mode_q;
	assign stat.held = held_q;

endmodule

// ===== sv/jcb_queue.sv =====
// Small FIFO of lexer results between front and back.
module jcb_queue import jcb_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic  clk,
	input  logic  arst_n,
	input  q_wr_t wr,
	input  logic  pop,
	output q_rd_t rd,
	output logic  full
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	q_entry_t        mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   cnt_q;

	function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (wr.push)
			mem_q[wr_ptr_q] <= wr.ent;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr.push)
				wr_ptr_q <= bump(wr_ptr_q);
			if (pop)
				rd_ptr_q <= bump(rd_ptr_q);
			if (wr.push && !pop)
				cnt_q <= cnt_q + CW'(1);
			else if (pop && !wr.push)
				cnt_q <= cnt_q - CW'(1);
		end
	end

	assign full     = (cnt_q == CW'(DEPTH));
	assign rd.empty = (cnt_q == '0);
	assign rd.head  = mem_q[rd_ptr_q];

endmodule

// ===== sv/jcb_back.sv =====
// Back end: serializes queued results into single output bytes.
module jcb_back import jcb_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  q_rd_t         rd,
	output logic          pop,
	jcb_stream_if.source  tx
);

	logic out_valid_q;
	out_t out_q;
	logic half_q;   // first byte of a two-byte head already sent
	logic load;

	assign load = !out_valid_q || tx.ready;
	assign pop  = load && !rd.empty && (!rd.head.two || half_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			half_q      <= 1'b0;
		end else if (load) begin
			out_valid_q <= !rd.empty;
			if (!rd.empty)
				half_q <= rd.head.two && !half_q;
		end
	end

	always_ff @(posedge clk) begin
		if (load && !rd.empty) begin
			if (rd.head.two && !half_q) begin
				out_q.out_byte  <= rd.head.b0;
				out_q.out_final <= 1'b0;
			end else begin
				out_q.out_byte  <= half_q ? rd.head.b1 : rd.head.b0;
				out_q.out_final <= rd.head.fin;
			end
		end
	end

	assign tx.valid   = out_valid_q;
	assign tx.payload = out_q;

endmodule

// ===== sv/json_comment_blanker.sv =====
// Top level of the streaming C-style comment blanker.
// Blanks /* */ and // comments outside double-quoted strings to spaces, keeping line breaks;
// a '/' or '*' waits one byte for its partner, so one input byte yields zero, one or two
// output bytes, and the last byte of a buffer (is_final) flushes and resets the lexer.
// Input takes one byte per cycle; the lexer decides a byte in the cycle it is accepted and
// drops its result into a QUEUE_DEPTH-entry queue. The output register sends one byte per
// cycle, so the two bytes of a paired result go out one after the other. The queue
// stalls input when the receiver holds off or when such pairs arrive faster than the
// output drains them.
// Each result passes through the queue and then the output register before output valid rises.
module json_comment_blanker import jcb_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	jcb_stream_if.sink   rx,
	jcb_stream_if.source tx
);

	q_wr_t     wr;
	q_rd_t     rd;
	logic      full;
	logic      pop;
	lex_stat_t stat;

	jcb_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.full   (full),
		.wr     (wr),
		.stat   (stat)
	);

	jcb_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.pop    (pop),
		.rd     (rd),
		.full   (full)
	);

	jcb_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.rd     (rd),
		.pop    (pop),
		.tx     (tx)
	);

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr.push |-> !full) else $error("queue push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !rd.empty) else $error("queue pop while empty");

	a_final_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(rx.valid && rx.ready && rx.payload.is_final) |=>
		(stat.mode == MODE_CODE && !stat.held)) else $error("lexer not reset after final");

	a_final_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(rx.valid && rx.ready && rx.payload.is_final) |-> wr.push)
		else $error("final byte produced no output");
`endif

endmodule
